### hw/rtl/bnc_pkg.sv
// Shared types, codes and constants of the bracket nesting checker.
`default_nettype none

package bnc_pkg;

  // Default number of stack entries.
  localparam int STACK_DEPTH_DEF = 64;

  // Depth of the operation queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Field widths.
  localparam int STATUS_W = 3;
  localparam int POINTS_W = 15;
  localparam int SUM_W    = 64;
  localparam int DEPTH_W  = 7;

  // Item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CORRUPT  = 3'd5;
  localparam logic [STATUS_W-1:0] ST_LINE_OK  = 3'd6;

  // Input item.
  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POINTS_W-1:0] error_points;
    logic [SUM_W-1:0]    error_total;
    logic [SUM_W-1:0]    completion_value;
    logic [DEPTH_W-1:0]  open_depth;
  } out_item_t;

  // Classified operation carried through the queue.
  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_IGNORE = 2'd2,
    OP_EOL    = 2'd3
  } op_code_t;

  typedef struct packed {
    op_code_t   code;
    logic [1:0] bkind;
  } op_t;

  // Error score of a mismatching closer.
  function automatic logic [POINTS_W-1:0] close_points(input logic [1:0] bkind);
    logic [POINTS_W-1:0] pts;
    case (bkind)
      2'd0:    pts = 15'd3;
      2'd1:    pts = 15'd57;
      2'd2:    pts = 15'd1197;
      default: pts = 15'd25137;
    endcase
    return pts;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/bnc_front.sv
// Front end: accepts input items, classifies each byte, hands ops to the queue.
`default_nettype none

module bnc_front
  import bnc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          q_push,
  output op_t           q_data,
  input  wire logic     q_full
);

  logic f_valid_r, f_valid_nxt;
  op_t  f_op_r;
  op_t  cls;
  logic accept;

  // Map an item to push, pop, ignore or end of line.
  always_comb begin
    cls.code  = OP_IGNORE;
    cls.bkind = 2'd0;
    if (in_item.kind == KIND_EOL) begin
      cls.code = OP_EOL;
    end else begin
      case (in_item.ch)
        8'h28: begin cls.code = OP_PUSH; cls.bkind = 2'd0; end
        8'h5B: begin cls.code = OP_PUSH; cls.bkind = 2'd1; end
        8'h7B: begin cls.code = OP_PUSH; cls.bkind = 2'd2; end
        8'h3C: begin cls.code = OP_PUSH; cls.bkind = 2'd3; end
        8'h29: begin cls.code = OP_POP;  cls.bkind = 2'd0; end
        8'h5D: begin cls.code = OP_POP;  cls.bkind = 2'd1; end
        8'h7D: begin cls.code = OP_POP;  cls.bkind = 2'd2; end
        8'h3E: begin cls.code = OP_POP;  cls.bkind = 2'd3; end
        default: begin cls.code = OP_IGNORE; cls.bkind = 2'd0; end
      endcase
    end
  end

  // Stage register holds one classified op until the queue has room.
  assign in_stall    = f_valid_r && q_full;
  assign accept      = in_valid && !in_stall;
  assign q_push      = f_valid_r && !q_full;
  assign q_data      = f_op_r;
  assign f_valid_nxt = accept || (f_valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_op_r <= cls;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bnc_fifo.sv
// Small op queue decoupling the front end from the stack engine.
`default_nettype none

module bnc_fifo
  import bnc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire op_t  wr_data,
  output logic      full,
  input  wire logic pop,
  output op_t       rd_data,
  output logic      not_empty
);

  op_t                 store [QUEUE_DEPTH];
  logic [QUEUE_AW:0]   wr_ptr_r, rd_ptr_r;

  assign full      = (wr_ptr_r[QUEUE_AW] != rd_ptr_r[QUEUE_AW]) &&
                     (wr_ptr_r[QUEUE_AW-1:0] == rd_ptr_r[QUEUE_AW-1:0]);
  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign rd_data   = store[rd_ptr_r[QUEUE_AW-1:0]];

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && not_empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      store[wr_ptr_r[QUEUE_AW-1:0]] <= wr_data;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bnc_back.sv
// Stack engine: runs queued ops against the opener stack and registers results.
`default_nettype none

module bnc_back
  import bnc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire op_t  q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_WALK = 4'b0100,
    S_EOL  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              corr_r, corr_nxt;
  logic [SUM_W-1:0]  err_sum_r, err_sum_nxt;
  logic [SUM_W-1:0]  acc_r, acc_nxt;
  logic [CW-1:0]     walk_left_r, walk_left_nxt;
  logic [AW-1:0]     walk_addr_r, walk_addr_nxt;
  logic [1:0]        pop_kind_r, pop_kind_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r;

  logic [1:0]        stack_mem [STACK_DEPTH];
  logic [1:0]        rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              mem_we;

  logic              out_free;
  logic              load;
  logic [STATUS_W-1:0] res_status;
  logic [POINTS_W-1:0] res_points;
  logic [SUM_W-1:0]    res_value;
  logic [CW-1:0]       cnt_m1, cnt_m2;

  assign out_free = !out_valid_r || !out_stall;
  assign cnt_m1   = cnt_r - CW'(1);
  assign cnt_m2   = cnt_r - CW'(2);

  // Control and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    corr_nxt      = corr_r;
    err_sum_nxt   = err_sum_r;
    acc_nxt       = acc_r;
    walk_left_nxt = walk_left_r;
    walk_addr_nxt = walk_addr_r;
    pop_kind_nxt  = pop_kind_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    mem_we        = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    rd_addr       = cnt_m1[AW-1:0];
    res_status    = ST_IGNORED;
    res_points    = '0;
    res_value     = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_data.code == OP_EOL) begin
            if (corr_r) begin
              load       = 1'b1;
              res_status = ST_CORRUPT;
              cnt_nxt    = '0;
              corr_nxt   = 1'b0;
            end else if (cnt_r == '0) begin
              load       = 1'b1;
              res_status = ST_LINE_OK;
            end else begin
              // top entry is being read this cycle
              acc_nxt       = '0;
              walk_left_nxt = cnt_r;
              walk_addr_nxt = cnt_m2[AW-1:0];
              state_nxt     = S_WALK;
            end
          end else if (corr_r) begin
            load       = 1'b1;
            res_status = ST_IGNORED;
          end else begin
            case (q_data.code)
              OP_PUSH: begin
                load = 1'b1;
                if (cnt_r == CW'(STACK_DEPTH)) begin
                  res_status = ST_FULL;
                end else begin
                  mem_we     = 1'b1;
                  cnt_nxt    = cnt_r + CW'(1);
                  res_status = ST_OK;
                end
              end
              OP_POP: begin
                if (cnt_r == '0) begin
                  load       = 1'b1;
                  res_status = ST_EMPTY;
                  corr_nxt   = 1'b1;
                end else begin
                  pop_kind_nxt = q_data.bkind;
                  state_nxt    = S_POP;
                end
              end
              default: begin
                load       = 1'b1;
                res_status = ST_IGNORED;
              end
            endcase
          end
        end
      end

      // Top entry now in rd_data_r.
      S_POP: begin
        if (out_free) begin
          load      = 1'b1;
          cnt_nxt   = cnt_m1;
          state_nxt = S_IDLE;
          if (rd_data_r == pop_kind_r) begin
            res_status = ST_OK;
          end else begin
            res_status  = ST_MISMATCH;
            res_points  = close_points(pop_kind_r);
            err_sum_nxt = err_sum_r + SUM_W'(close_points(pop_kind_r));
            corr_nxt    = 1'b1;
          end
        end
      end

      // One entry per cycle, top to bottom: acc = acc*5 + kind + 1.
      S_WALK: begin
        rd_addr       = walk_addr_r;
        acc_nxt       = acc_r + {acc_r[SUM_W-3:0], 2'b00} +
                        SUM_W'(rd_data_r) + SUM_W'(1);
        walk_addr_nxt = walk_addr_r - AW'(1);
        walk_left_nxt = walk_left_r - CW'(1);
        if (walk_left_r == CW'(1)) begin
          state_nxt = S_EOL;
        end
      end

      S_EOL: begin
        if (out_free) begin
          load       = 1'b1;
          res_status = ST_LINE_OK;
          res_value  = acc_r;
          cnt_nxt    = '0;
          corr_nxt   = 1'b0;
          state_nxt  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      corr_r      <= 1'b0;
      err_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      corr_r      <= corr_nxt;
      err_sum_r   <= err_sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    walk_left_r <= walk_left_nxt;
    walk_addr_r <= walk_addr_nxt;
    pop_kind_r  <= pop_kind_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_item_r.status           <= res_status;
      out_item_r.error_points     <= res_points;
      out_item_r.error_total      <= err_sum_nxt;
      out_item_r.completion_value <= res_value;
      out_item_r.open_depth       <= DEPTH_W'(cnt_nxt);
    end
  end

  // Opener stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= q_data.bkind;
    end
    rd_data_r <= stack_mem[rd_addr];
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### hw/rtl/bracket_nesting_checker.sv
// A character result passes the front stage register, op queue and result register;
// a popping closer also waits on the registered stack read. End of line walks the stack
// at one entry per cycle. Openers and ignored bytes go at one character per cycle unless
// the result side stalls; a pop or a stack walk holds the engine off the next op.
// Reset (rst_n low, synchronous) clears counts, flags, error total and queues;
// stack contents are not cleared and need no clearing pass.
`default_nettype none

module bracket_nesting_checker
  import bnc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  logic q_push, q_full, q_pop, q_valid;
  op_t  q_wr_data, q_rd_data;

  bnc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_data   (q_wr_data),
    .q_full   (q_full)
  );

  bnc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (q_rd_data),
    .not_empty (q_valid)
  );

  bnc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### verif/bnc_checker.sv
// Checker for the bracket nesting checker: predicts each result and compares it.
`timescale 1ns / 100ps

module bnc_checker
  import bnc_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        pending,
  output int        fail_count
);

  localparam string OPENERS = "([{<";
  localparam string CLOSERS = ")]}>";
  localparam logic [POINTS_W-1:0] MISMATCH_SCORE [4] = '{15'd3, 15'd57, 15'd1197, 15'd25137};

  // Shadow line state
  logic [1:0]       opener_kinds [STACK_DEPTH];
  int               open_count = 0;
  bit               line_bad = 1'b0;
  logic [SUM_W-1:0] score_total = '0;

  out_item_t        bracket_results [$];
  out_item_t        predicted;
  out_item_t        oldest;
  int               errs = 0;

  assign fail_count = errs;

  // Advance the shadow state by one item and return the result it should give.
  task automatic bracket_step(input in_item_t it, output out_item_t res);
    logic [SUM_W-1:0] comp;
    int               ok;
    int               ck;
    int               i;
    comp = '0;
    ok = -1;
    ck = -1;
    res = '0;
    res.status = ST_IGNORED;
    if (it.kind == KIND_EOL) begin
      if (line_bad) begin
        res.status = ST_CORRUPT;
      end else begin
        res.status = ST_LINE_OK;
        // walk from the top of the stack, base 5, wrapping at 64 bits
        for (i = open_count - 1; i >= 0; i--) begin
          comp = comp * 64'd5 + 64'(opener_kinds[i]) + 64'd1;
        end
      end
      open_count = 0;
      line_bad = 1'b0;
    end else if (!line_bad) begin
      for (i = 0; i < 4; i++) begin
        if (it.ch == OPENERS[i]) ok = i;
        if (it.ch == CLOSERS[i]) ck = i;
      end
      if (ok >= 0) begin
        if (open_count >= STACK_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          opener_kinds[open_count] = ok[1:0];
          open_count++;
          res.status = ST_OK;
        end
      end else if (ck >= 0) begin
        if (open_count == 0) begin
          res.status = ST_EMPTY;
          line_bad = 1'b1;
        end else begin
          open_count--;
          if (opener_kinds[open_count] == ck[1:0]) begin
            res.status = ST_OK;
          end else begin
            res.status = ST_MISMATCH;
            res.error_points = MISMATCH_SCORE[ck];
            score_total += 64'(MISMATCH_SCORE[ck]);
            line_bad = 1'b1;
          end
        end
      end
    end
    res.error_total = score_total;
    res.completion_value = comp;
    res.open_depth = DEPTH_W'(open_count);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endtask

  // Watch both channels; inputs and outputs are sampled before this edge's updates
  always @(posedge clk) begin
    if (!rst_n) begin
      open_count = 0;
      line_bad = 1'b0;
      score_total = '0;
      bracket_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        bracket_step(in_item, predicted);
        bracket_results.insert(bracket_results.size(), predicted);
      end
      if (out_valid && !out_stall) begin
        if (bracket_results.size() == 0) begin
          $error("unexpected result item: status %0d, open_depth %0d",
                 out_item.status, out_item.open_depth);
          errs++;
        end else begin
          oldest = bracket_results.pop_front();
          check_field("status", 64'(oldest.status), 64'(out_item.status));
          check_field("error_points", 64'(oldest.error_points), 64'(out_item.error_points));
          check_field("error_total", oldest.error_total, out_item.error_total);
          check_field("completion_value", oldest.completion_value,
                      out_item.completion_value);
          check_field("open_depth", 64'(oldest.open_depth), 64'(out_item.open_depth));
        end
      end
    end
    pending <= bracket_results.size();
  end

endmodule

### verif/testbench.sv
// Top of the bracket nesting checker testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
  import bnc_pkg::*;

  localparam int    RANDOM_ITEMS = 1450;
  localparam int    QUIET_TAIL   = 200;
  localparam int    DRAIN_CYCLES = 100;
  localparam string OPENERS      = "([{<";
  localparam string CLOSERS      = ")]}>";

  // Kinds of generated lines
  localparam int LINE_WELL   = 0;
  localparam int LINE_DEEP   = 1;
  localparam int LINE_BROKEN = 2;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int pending;
  int fail_count;
  int sent = 0;
  int random_end;
  bit idle_en = 1'b1;

  bracket_nesting_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  bnc_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one item, with an occasional gap first, and wait until it is taken
  task automatic send_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t it;
    it.kind = KIND_CHAR;
    it.ch = c;
    send_item(it);
  endtask

  task automatic send_eol();
    in_item_t it;
    it.kind = KIND_EOL;
    it.ch = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // Any byte that is not one of the eight brackets
  function automatic logic [7:0] noise_byte();
    logic [7:0] c;
    bit         hit;
    int         k;
    do begin
      c = 8'($urandom_range(0, 255));
      hit = 1'b0;
      for (k = 0; k < 4; k++) begin
        if (c == OPENERS[k] || c == CLOSERS[k]) hit = 1'b1;
      end
    end while (hit);
    return c;
  endfunction

  // One line of the given flavor, ended by an end-of-line item
  task automatic random_line(input int flavor);
    int shadow [STACK_DEPTH_DEF];
    int depth;
    int len;
    int cap;
    int k;
    int r;
    depth = 0;
    case (flavor)
      LINE_WELL: begin
        len = $urandom_range(1, 30);
        cap = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 8) begin
            send_char(noise_byte());
          end else if (depth == 0 || (depth < cap && r < 55)) begin
            k = $urandom_range(0, 3);
            shadow[depth] = k;
            depth++;
            send_char(OPENERS[k]);
          end else begin
            depth--;
            send_char(CLOSERS[shadow[depth]]);
          end
        end
        // half the lines are closed completely, the rest stay incomplete
        if ($urandom_range(0, 1) == 1) begin
          while (depth != 0) begin
            depth--;
            send_char(CLOSERS[shadow[depth]]);
          end
        end
      end
      LINE_DEEP: begin
        // push 60 to 70 openers, which can fill the stack and push past it
        repeat ($urandom_range(60, 70)) begin
          k = $urandom_range(0, 3);
          if (depth < STACK_DEPTH_DEF) begin
            shadow[depth] = k;
            depth++;
          end
          send_char(OPENERS[k]);
        end
        repeat ($urandom_range(0, 5)) begin
          depth--;
          send_char(CLOSERS[shadow[depth]]);
        end
      end
      default: begin
        len = $urandom_range(1, 15);
        repeat (len) begin
          if ($urandom_range(0, 99) < 70) begin
            k = $urandom_range(0, 7);
            send_char(k < 4 ? OPENERS[k] : CLOSERS[k - 4]);
          end else begin
            send_char(8'($urandom_range(0, 255)));
          end
        end
      end
    endcase
    send_eol();
  endtask

  // Result side stalls in bursts
  initial begin
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int r;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every opener, and an ignored byte at the top of the range
    send_text("({[<");
    send_char(8'hFF);
    send_text(">");
    send_eol();
    // one mismatch per closer kind, then a char after corruption
    send_text("[))");
    send_eol();
    send_text("(]");
    send_eol();
    send_text("(}");
    send_eol();
    send_text("(>");
    send_eol();
    // closer on an empty stack, then an ignored byte at the bottom of the range
    send_text(")");
    send_char(8'h00);
    send_eol();
    // empty line
    send_eol();

    random_end = sent + RANDOM_ITEMS;
    random_line(LINE_DEEP);
    while (sent < random_end) begin
      idle_en = (sent < random_end - QUIET_TAIL) && ((sent / 200) % 4 != 3);
      r = $urandom_range(0, 99);
      random_line(r < 70 ? LINE_WELL : (r < 80 ? LINE_DEEP : LINE_BROKEN));
    end
    idle_en = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("bracket_nesting_checker: match");
    end else begin
      $display("bracket_nesting_checker: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #7_000_000;
    $display("bracket_nesting_checker: mismatch");
    $finish;
  end

endmodule
